FILE: rtl/pli_pkg.sv
`default_nettype none

package pli_pkg;

   localparam int DATA_W         = 32;
   localparam int IDX_W          = 8;
   localparam int CSR_W          = 9;
   localparam int STATUS_W       = 2;
   localparam int MAX_POINTS_DEF = 256;
   localparam int MIN_POINTS     = 2;
   localparam int DIFF_W         = DATA_W + 1;
   localparam int MAG_W          = DATA_W;
   localparam int PROD_W         = 2 * MAG_W;
   localparam int ITER_W         = $clog2(PROD_W);
   localparam int SAT_BIT        = DATA_W + 1;
   localparam int SUM_W          = DATA_W + 4;

   localparam logic [CSR_W-1:0] CSR_RESET = CSR_W'(MIN_POINTS);

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK         = 2'd0,
      STATUS_ZERO_WIDTH = 2'd1,
      STATUS_FEW_POINTS = 2'd2
   } status_type;

   typedef struct packed {
      logic                     operation;
      logic [IDX_W-1:0]         point_index;
      logic signed [DATA_W-1:0] point_x;
      logic signed [DATA_W-1:0] point_y;
      logic signed [DATA_W-1:0] query_x;
   } req_word_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] y_value;
      status_type               status;
   } rsp_word_type;

   typedef struct packed {
      logic       load_en;
      logic       query_capture;
      logic       scan_eval;
      logic       scan_first;
      logic       scan_last;
      logic       prep;
      logic       mul;
      logic       div_step;
      logic       rsp_load;
      status_type rsp_status;
   } cmd_type;

   typedef struct packed {
      logic dx_zero;
   } dp_status_type;

endpackage

`default_nettype wire

FILE: rtl/piecewise_linear_interpolator.sv
`default_nettype none

// A load word is written into the breakpoint tables in the cycle in which it is accepted.
// A query with n points in use scans the tables, reading one breakpoint per cycle, then
// prepares the operands, multiplies, and runs the divider, which forms one quotient bit per
// cycle; a zero-width segment skips the divider, and too few points go straight to the result.
// One query is worked on at a time; the next word can be taken in the first cycle the result
// is shown. Reset clears the controller and sets the point count to 2; the tables are not
// cleared.

module piecewise_linear_interpolator #(
   parameter int MAX_POINTS = pli_pkg::MAX_POINTS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  pli_pkg::req_word_type     req_word,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output pli_pkg::rsp_word_type     rsp_word,
   input  logic                      csr_write_enable,
   input  logic [pli_pkg::CSR_W-1:0] csr_write_data
);

   import pli_pkg::*;

   cmd_type                       cmd;
   dp_status_type                 dp_status;
   logic [$clog2(MAX_POINTS)-1:0] scan_addr;

   pli_ctrl #(
      .MAX_POINTS(MAX_POINTS)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_word.operation),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .dp_status       (dp_status),
      .cmd             (cmd),
      .scan_addr       (scan_addr)
   );

   pli_datapath #(
      .MAX_POINTS(MAX_POINTS)
   ) u_datapath (
      .clock    (clock),
      .cmd      (cmd),
      .scan_addr(scan_addr),
      .req_word (req_word),
      .dp_status(dp_status),
      .rsp_word (rsp_word)
   );

endmodule

`default_nettype wire

FILE: rtl/pli_ram.sv
`default_nettype none

module pli_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/pli_datapath.sv
`default_nettype none

module pli_datapath #(
   parameter int MAX_POINTS = 256
) (
   input  logic                          clock,
   input  pli_pkg::cmd_type              cmd,
   input  logic [$clog2(MAX_POINTS)-1:0] scan_addr,
   input  pli_pkg::req_word_type         req_word,
   output pli_pkg::dp_status_type        dp_status,
   output pli_pkg::rsp_word_type         rsp_word
);

   import pli_pkg::*;

   localparam int AW = $clog2(MAX_POINTS);

   localparam logic signed [DATA_W-1:0] Y_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] Y_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   logic                     wr_en;
   logic [AW-1:0]            wr_addr;
   logic [DATA_W-1:0]        x_rd;
   logic [DATA_W-1:0]        y_rd;

   logic signed [DATA_W-1:0] q_ff, q_in;
   logic signed [DATA_W-1:0] prev_x_ff, prev_x_in;
   logic signed [DATA_W-1:0] prev_y_ff, prev_y_in;
   logic signed [DATA_W-1:0] x0_ff, x0_in;
   logic signed [DATA_W-1:0] x1_ff, x1_in;
   logic signed [DATA_W-1:0] y0_ff, y0_in;
   logic signed [DATA_W-1:0] y1_ff, y1_in;
   logic [MAG_W-1:0]         mcand_ff, mcand_in;
   logic [MAG_W-1:0]         mplier_ff, mplier_in;
   logic [MAG_W-1:0]         divisor_ff, divisor_in;
   logic                     neg_ff, neg_in;
   logic [PROD_W-1:0]        acc_ff, acc_in;
   logic [MAG_W-1:0]         rem_ff, rem_in;
   rsp_word_type             rsp_word_ff, rsp_word_in;

   logic signed [DATA_W-1:0] x_hi;
   logic                     ge_lo;
   logic                     lt_hi;
   logic                     seg_match;
   logic signed [DIFF_W-1:0] dx;
   logic signed [DIFF_W-1:0] dy;
   logic signed [DIFF_W-1:0] dq;
   logic [MAG_W:0]           shifted;
   logic [MAG_W:0]           trial;
   logic                     quo_bit;
   logic                     sat_big;
   logic signed [SUM_W-1:0]  quo_ext;
   logic signed [SUM_W-1:0]  term;
   logic signed [SUM_W-1:0]  sum;
   logic                     sum_fits;
   logic signed [DATA_W-1:0] y_result;

   assign wr_en   = cmd.load_en && (32'(req_word.point_index) < 32'(MAX_POINTS));
   assign wr_addr = AW'(req_word.point_index);

   pli_ram #(
      .WIDTH(DATA_W),
      .DEPTH(MAX_POINTS)
   ) u_x_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(req_word.point_x),
      .rd_addr(scan_addr),
      .rd_data(x_rd)
   );

   pli_ram #(
      .WIDTH(DATA_W),
      .DEPTH(MAX_POINTS)
   ) u_y_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(req_word.point_y),
      .rd_addr(scan_addr),
      .rd_data(y_rd)
   );

   // A segment is compared as soon as both of its end points have been read.
   assign x_hi      = $signed(x_rd);
   assign ge_lo     = q_ff >= prev_x_ff;
   assign lt_hi     = q_ff < x_hi;
   assign seg_match = (ge_lo && lt_hi) || (cmd.scan_first && !ge_lo) ||
                      (cmd.scan_last && !lt_hi);

   assign dx = DIFF_W'(x1_ff) - DIFF_W'(x0_ff);
   assign dy = DIFF_W'(y1_ff) - DIFF_W'(y0_ff);
   assign dq = DIFF_W'(q_ff) - DIFF_W'(x0_ff);

   assign dp_status.dx_zero = (x0_ff == x1_ff);

   assign shifted = {rem_ff, acc_ff[PROD_W-1]};
   assign trial   = shifted - {1'b0, divisor_ff};
   assign quo_bit = shifted >= {1'b0, divisor_ff};

   assign sat_big  = (|acc_ff[PROD_W-1:SAT_BIT+1]) ||
                     (acc_ff[SAT_BIT] && (|acc_ff[SAT_BIT-1:0]));
   assign quo_ext  = $signed(SUM_W'(acc_ff[SAT_BIT:0]));
   assign term     = neg_ff ? -quo_ext : quo_ext;
   assign sum      = SUM_W'(y0_ff) + term;
   assign sum_fits = (sum[SUM_W-1:DATA_W-1] == '0) || (sum[SUM_W-1:DATA_W-1] == '1);

   always_comb begin
      if (sat_big) begin
         y_result = neg_ff ? Y_MIN : Y_MAX;
      end else if (sum_fits) begin
         y_result = sum[DATA_W-1:0];
      end else begin
         y_result = sum[SUM_W-1] ? Y_MIN : Y_MAX;
      end
   end

   always_comb begin
      q_in        = q_ff;
      prev_x_in   = prev_x_ff;
      prev_y_in   = prev_y_ff;
      x0_in       = x0_ff;
      x1_in       = x1_ff;
      y0_in       = y0_ff;
      y1_in       = y1_ff;
      mcand_in    = mcand_ff;
      mplier_in   = mplier_ff;
      divisor_in  = divisor_ff;
      neg_in      = neg_ff;
      acc_in      = acc_ff;
      rem_in      = rem_ff;
      rsp_word_in = rsp_word_ff;

      if (cmd.query_capture) begin
         q_in = req_word.query_x;
      end

      prev_x_in = $signed(x_rd);
      prev_y_in = $signed(y_rd);
      if (cmd.scan_eval && (cmd.scan_first || seg_match)) begin
         x0_in = prev_x_ff;
         x1_in = $signed(x_rd);
         y0_in = prev_y_ff;
         y1_in = $signed(y_rd);
      end

      if (cmd.prep) begin
         mcand_in   = dy[DIFF_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
         mplier_in  = dq[DIFF_W-1] ? MAG_W'(-dq) : MAG_W'(dq);
         divisor_in = dx[DIFF_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
         neg_in     = dx[DIFF_W-1] ^ dy[DIFF_W-1] ^ dq[DIFF_W-1];
         rem_in     = '0;
      end

      if (cmd.mul) begin
         acc_in = PROD_W'(mcand_ff) * PROD_W'(mplier_ff);
      end

      if (cmd.div_step) begin
         rem_in = quo_bit ? trial[MAG_W-1:0] : shifted[MAG_W-1:0];
         acc_in = {acc_ff[PROD_W-2:0], quo_bit};
      end

      if (cmd.rsp_load) begin
         rsp_word_in.y_value = (cmd.rsp_status == STATUS_OK) ? y_result : '0;
         rsp_word_in.status  = cmd.rsp_status;
      end
   end

   always_ff @(posedge clock) begin
      q_ff        <= q_in;
      prev_x_ff   <= prev_x_in;
      prev_y_ff   <= prev_y_in;
      x0_ff       <= x0_in;
      x1_ff       <= x1_in;
      y0_ff       <= y0_in;
      y1_ff       <= y1_in;
      mcand_ff    <= mcand_in;
      mplier_ff   <= mplier_in;
      divisor_ff  <= divisor_in;
      neg_ff      <= neg_in;
      acc_ff      <= acc_in;
      rem_ff      <= rem_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_word = rsp_word_ff;

endmodule

`default_nettype wire

FILE: rtl/pli_ctrl.sv
`default_nettype none

module pli_ctrl #(
   parameter int MAX_POINTS = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_operation,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic                          csr_write_enable,
   input  logic [pli_pkg::CSR_W-1:0]     csr_write_data,
   input  pli_pkg::dp_status_type        dp_status,
   output pli_pkg::cmd_type              cmd,
   output logic [$clog2(MAX_POINTS)-1:0] scan_addr
);

   import pli_pkg::*;

   localparam int AW       = $clog2(MAX_POINTS);
   localparam int CNT_W    = ($clog2(MAX_POINTS + 1) > CSR_W) ? $clog2(MAX_POINTS + 1) : CSR_W;
   localparam int SCAN_LAG = 2;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_SCAN = 6'b000010,
      ST_PREP = 6'b000100,
      ST_MUL  = 6'b001000,
      ST_DIV  = 6'b010000,
      ST_DONE = 6'b100000
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  scan_cnt_ff, scan_cnt_in;
   logic [ITER_W-1:0] iter_cnt_ff, iter_cnt_in;
   status_type        status_ff, status_in;
   logic [CSR_W-1:0]  points_ff, points_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [CNT_W-1:0]  points_ext;
   logic [CNT_W-1:0]  n_eff;
   logic              few_points;

   assign points_ext = CNT_W'(points_ff);
   assign n_eff      = (points_ext > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : points_ext;
   assign few_points = n_eff < CNT_W'(MIN_POINTS);

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign scan_addr = scan_cnt_ff[AW-1:0];

   always_comb begin
      state_in       = state_ff;
      scan_cnt_in    = scan_cnt_ff;
      iter_cnt_in    = iter_cnt_ff;
      status_in      = status_ff;
      cmd            = '0;
      cmd.rsp_status = status_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_operation == OP_QUERY) begin
                  cmd.query_capture = 1'b1;
                  scan_cnt_in       = '0;
                  if (few_points) begin
                     status_in = STATUS_FEW_POINTS;
                     state_in  = ST_DONE;
                  end else begin
                     status_in = STATUS_OK;
                     state_in  = ST_SCAN;
                  end
               end else begin
                  cmd.load_en = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan_eval  = scan_cnt_ff >= CNT_W'(SCAN_LAG);
            cmd.scan_first = scan_cnt_ff == CNT_W'(SCAN_LAG);
            cmd.scan_last  = scan_cnt_ff == n_eff;
            if (scan_cnt_ff == n_eff) begin
               state_in = ST_PREP;
            end else begin
               scan_cnt_in = scan_cnt_ff + 1'b1;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            if (dp_status.dx_zero) begin
               status_in = STATUS_ZERO_WIDTH;
               state_in  = ST_DONE;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul     = 1'b1;
            iter_cnt_in = ITER_W'(PROD_W - 1);
            state_in    = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (iter_cnt_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               iter_cnt_in = iter_cnt_ff - 1'b1;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign points_in = csr_write_enable ? csr_write_data : points_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_cnt_ff  <= '0;
         iter_cnt_ff  <= '0;
         status_ff    <= STATUS_OK;
         points_ff    <= CSR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_cnt_ff  <= scan_cnt_in;
         iter_cnt_ff  <= iter_cnt_in;
         status_ff    <= status_in;
         points_ff    <= points_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_few_points: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_operation == OP_QUERY) && few_points) |=>
      ((state_ff == ST_DONE) && (status_ff == STATUS_FEW_POINTS)))
      else $error("Query with too few points did not go straight to the result.");

   a_zero_width: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_PREP) && dp_status.dx_zero) |=>
      ((state_ff == ST_DONE) && (status_ff == STATUS_ZERO_WIDTH)))
      else $error("Zero-width segment did not skip the divider.");

   a_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("Result register overwritten while its word was still waiting.");

   a_div_end: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DIV) && (iter_cnt_ff == '0)) |=> (state_ff == ST_DONE))
      else $error("Divider did not finish after its last step.");

endmodule

`default_nettype wire
